@@ src/vln_pkg.sv @@
`timescale 1ns / 1ps
// vln_pkg: shared constants, types and request structs for the vector L2 normalizer.
// No dependencies; every other file imports it.
package vln_pkg;

  // Vector geometry
  localparam int MaxLen = 64;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int CntW   = $clog2(MaxLen + 1);

  // Field widths
  localparam int ElemW  = 16;
  localparam int NormW  = 19;
  localparam int SqW    = 31;
  localparam int SumW   = 37;
  localparam int TdataOutW = 40;

  // Square root: one result bit per cycle
  localparam int RootIter = (SumW + 1) / 2;

  // Divider: quotient bits per cycle and cycles per element
  localparam int QuotW    = 16;
  localparam int DivStep  = 4;
  localparam int DivCycles = QuotW / DivStep;
  localparam int DivCntW  = $clog2(DivCycles);

  // Saturation bounds of the Q1.15 result magnitude
  localparam logic [QuotW-1:0] PosMax = 16'h7fff;
  localparam logic [QuotW-1:0] NegMax = 16'h8000;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [NormW-1:0]        norm_t;
  typedef logic [SumW-1:0]         sum_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Element store write request
  typedef struct packed {
    logic  en;
    addr_t addr;
    elem_t data;
  } store_wr_t;

  // Element store read request
  typedef struct packed {
    logic  en;
    addr_t addr;
  } store_rd_t;

endpackage

@@ src/vector_l2_normalize.sv @@
`timescale 1ns / 1ps
// vector_l2_normalize: top level; loads elements, forms the norm and emits
// normalized elements. Depends on vln_pkg, vln_store, vln_isqrt, vln_scale.
//
//  channel  | direction | tdata (low bit up)            | tlast
//  s_axis   | in        | element[15:0]                 | is_last
//  m_axis   | out       | unit_element[15:0], norm[34:16] | is_final
//
// Loading takes one element per cycle while idle; the square is summed in the next cycle.
// Closing a vector goes through a flush state, then 19 root digits and a done pulse.
// Each result then passes a store read, a divider load, the divider steps at four quotient
// bits each, a done pulse, and a push into the output register.
// Inputs stall from the closing element until the last result is pushed.
// Reset clears control, count and sum; the element store is not cleared.
module vector_l2_normalize (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // element[15:0]
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // unit_element[15:0], norm[34:16], zero[39:35]
  output logic                  m_axis_tlast
);
  import vln_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FLUSH   = 3'd1;
  localparam logic [2:0] S_ROOT    = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_DIVGO   = 3'd4;
  localparam logic [2:0] S_DIVWAIT = 3'd5;
  localparam logic [2:0] S_PUSH    = 3'd6;

  logic [2:0]       state_q, state_d;
  cnt_t             cnt_q, cnt_d;
  addr_t            k_q, k_d;
  sum_t             sum_q, sum_d;
  logic [SqW-1:0]   sq_q;
  logic             sq_vld_q;
  norm_t            norm_q;

  logic             m_valid_q;
  elem_t            m_unit_q;
  norm_t            m_norm_q;
  logic             m_last_q;

  logic             in_acc;
  logic             closing;
  logic             push;
  logic             is_final;
  elem_t            elem_in;
  logic signed [2*ElemW-1:0] prod;

  store_wr_t        wr;
  store_rd_t        rd;
  elem_t            rdata;
  logic             root_done;
  norm_t            root;
  logic             div_done;
  elem_t            unit;

  assign elem_in       = elem_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign closing       = s_axis_tlast || (cnt_q == CntW'(MaxLen - 1));
  assign push          = (state_q == S_PUSH) && (!m_valid_q || m_axis_tready);
  assign is_final      = (CntW'({1'b0, k_q}) + 1'b1) == cnt_q;
  assign prod          = elem_in * elem_in;

  // Store requests
  assign wr.en   = in_acc;
  assign wr.addr = cnt_q[AddrW-1:0];
  assign wr.data = elem_in;
  assign rd.en   = (state_q == S_READ);
  assign rd.addr = k_q;

  vln_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  vln_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_FLUSH),
    .value_i (sum_d),
    .done_o  (root_done),
    .root_o  (root)
  );

  vln_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIVGO),
    .elem_i  (rdata),
    .norm_i  (norm_q),
    .done_o  (div_done),
    .unit_o  (unit)
  );

  // Accumulate the pending square; clear once the root is taken
  always_comb begin
    sum_d = sum_q;
    if (sq_vld_q) begin
      sum_d = sum_q + SumW'(sq_q);
    end
    if ((state_q == S_ROOT) && root_done) begin
      sum_d = '0;
    end
  end

  // Sequence load, root and per-element scaling
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d = cnt_q + 1'b1;
          if (closing) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          k_d     = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        state_d = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (div_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push) begin
          if (is_final) begin
            cnt_d   = '0;
            k_d     = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      k_q       <= '0;
      sum_q     <= '0;
      sq_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      sum_q    <= sum_d;
      sq_vld_q <= in_acc;
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: square, norm and output item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sq_q <= prod[SqW-1:0];
    end
    if ((state_q == S_ROOT) && root_done) begin
      norm_q <= root;
    end
    if (push) begin
      m_unit_q <= unit;
      m_norm_q <= norm_q;
      m_last_q <= is_final;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TdataOutW - NormW - ElemW){1'b0}}, m_norm_q, m_unit_q};
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  a_root_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == S_ROOT))
    else $error("root done outside root state");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVWAIT))
    else $error("divider done outside wait state");

  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (((38'(root) * 38'(root)) <= 38'(sum_q))
                && (((38'(root) + 38'd1) * (38'(root) + 38'd1)) > 38'(sum_q))))
    else $error("root is not the floor square root of the sum");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (CntW'({1'b0, k_q}) < cnt_q))
    else $error("store read beyond loaded elements");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && is_final) |=> ((cnt_q == '0) && (sum_q == '0) && (state_q == S_IDLE)))
    else $error("count or sum not cleared after last result");
`endif

endmodule

@@ src/vln_store.sv @@
`timescale 1ns / 1ps
// vln_store: element buffer, one write port and one registered read port.
// Depends on vln_pkg.
module vln_store (
  input  logic               clk_i,
  input  vln_pkg::store_wr_t wr_i,
  input  vln_pkg::store_rd_t rd_i,
  output vln_pkg::elem_t     rdata_o
);
  import vln_pkg::*;

  elem_t mem_q [MaxLen];
  elem_t rdata_q;

  // Write one element
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/vln_isqrt.sv @@
`timescale 1ns / 1ps
// vln_isqrt: iterative floor square root, one result bit per cycle.
// Depends on vln_pkg.
module vln_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vln_pkg::sum_t value_i,
  output logic          done_o,
  output vln_pkg::norm_t root_o
);
  import vln_pkg::*;

  logic        busy_q;
  logic        done_q;
  sum_t        v_q;
  sum_t        root_q;
  sum_t        bit_q;
  logic [SumW:0] trial;
  logic        take;

  // Trial subtraction of the current digit
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign take  = ({1'b0, v_q} >= trial);

  // Control: busy while digits remain, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: remainder, partial root and digit weight
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      root_q <= '0;
      bit_q  <= {1'b1, {(SumW-1){1'b0}}};
    end else if (busy_q) begin
      if (take) begin
        v_q    <= v_q - trial[SumW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[NormW-1:0];

endmodule

@@ src/vln_scale.sv @@
`timescale 1ns / 1ps
// vln_scale: element * 32768 / norm by restoring division, four quotient
// bits per cycle, with sign handling and Q1.15 saturation. Depends on vln_pkg.
module vln_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vln_pkg::elem_t elem_i,
  input  vln_pkg::norm_t norm_i,
  output logic           done_o,
  output vln_pkg::elem_t unit_o
);
  import vln_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  norm_t              norm_q;
  norm_t              r_q;
  logic [QuotW-1:0]   d_q;
  logic [QuotW-1:0]   q_q;
  logic               neg_q;
  logic               zero_q;
  elem_t              elem_q;
  elem_t              unit_q;

  logic [ElemW-1:0]   mag;
  norm_t              r_d;
  logic [QuotW-1:0]   d_d;
  logic [QuotW-1:0]   q_d;
  logic [NormW:0]     rr;
  logic [QuotW-1:0]   sat;
  elem_t              unit_d;

  assign mag = elem_i[ElemW-1] ? ElemW'(-elem_i) : ElemW'(elem_i);

  // Four restoring division steps
  always_comb begin
    r_d = r_q;
    d_d = d_q;
    q_d = q_q;
    rr  = '0;
    for (int j = 0; j < DivStep; j++) begin
      rr  = {r_d, d_d[QuotW-1]};
      d_d = {d_d[QuotW-2:0], 1'b0};
      if (rr >= {1'b0, norm_q}) begin
        r_d = NormW'(rr - {1'b0, norm_q});
        q_d = {q_d[QuotW-2:0], 1'b1};
      end else begin
        r_d = rr[NormW-1:0];
        q_d = {q_d[QuotW-2:0], 1'b0};
      end
    end
  end

  // Apply sign and saturate; a zero norm passes the element through
  always_comb begin
    sat    = '0;
    unit_d = elem_q;
    if (!zero_q) begin
      if (neg_q) begin
        sat    = (q_d > NegMax) ? NegMax : q_d;
        unit_d = elem_t'(ElemW'(-sat));
      end else begin
        sat    = (q_d > PosMax) ? PosMax : q_d;
        unit_d = elem_t'(sat);
      end
    end
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then iterate; hold result until the next run ends
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      norm_q <= norm_i;
      r_q    <= NormW'(mag[ElemW-1:1]);
      d_q    <= {mag[0], {(QuotW-1){1'b0}}};
      q_q    <= '0;
      neg_q  <= elem_i[ElemW-1];
      zero_q <= (norm_i == '0);
      elem_q <= elem_i;
    end else if (busy_q) begin
      r_q <= r_d;
      d_q <= d_d;
      q_q <= q_d;
      if (cnt_q == DivCntW'(DivCycles - 1)) begin
        unit_q <= unit_d;
      end
    end
  end

  assign done_o = done_q;
  assign unit_o = unit_q;

endmodule

@@ tb/tb_vector_l2_normalize.sv @@
`timescale 1ns / 1ps
// tb_vector_l2_normalize: self-checking bench for the vector L2 normalizer, with a
// directed table, random vectors, idle/stall phases and a scoreboard. Depends on vln_pkg.
module tb_vector_l2_normalize;
  import vln_pkg::*;

  // One normalized element as it leaves the block, unit element in the top bits
  typedef struct packed {
    logic [15:0] unit;
    norm_t       norm;
    logic        fin;
  } unit_res_t;

  // Directed row; res is used only where typed is set
  typedef struct packed {
    logic [15:0] elem;
    logic        last;
    logic        typed;
    unit_res_t   res;
  } dir_row_t;

  localparam int DirN      = 20;
  localparam int RandItems = 290;
  localparam int PhaseLen  = 40;

  localparam dir_row_t DirTab [DirN] = '{
    // single-element vectors: zero norm, extremes, full scale
    '{16'h0000, 1'b1, 1'b1, '{16'h0000, 19'd0,     1'b1}},
    '{16'h7fff, 1'b1, 1'b1, '{16'h7fff, 19'd32767, 1'b1}},
    '{16'h8000, 1'b1, 1'b1, '{16'h8000, 19'd32768, 1'b1}},
    '{16'h1000, 1'b1, 1'b1, '{16'h7fff, 19'd4096,  1'b1}},
    '{16'hf000, 1'b1, 1'b1, '{16'h8000, 19'd4096,  1'b1}},
    '{16'h0001, 1'b1, 1'b1, '{16'h7fff, 19'd1,     1'b1}},
    '{16'hffff, 1'b1, 1'b1, '{16'h8000, 19'd1,     1'b1}},
    // 3-4-5 triangle
    '{16'h3000, 1'b0, 1'b0, '0},
    '{16'h4000, 1'b1, 1'b0, '0},
    // zero norm over several elements
    '{16'h0000, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b1, 1'b0, '0},
    // mixed extremes
    '{16'h7fff, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, '0},
    '{16'h1234, 1'b1, 1'b0, '0},
    // truncation toward zero on both signs
    '{16'hfffd, 1'b0, 1'b0, '0},
    '{16'h0005, 1'b1, 1'b0, '0},
    '{16'h0064, 1'b0, 1'b0, '0},
    '{16'hff9c, 1'b0, 1'b0, '0},
    '{16'h0001, 1'b1, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // element[15:0]
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // unit_element[15:0], norm[34:16], zero[39:35]
  logic        m_axis_tlast;

  // Predictor state and scoreboard
  elem_t     vec_q[$];
  sum_t      sq_acc = '0;
  unit_res_t unit_due_q[$];
  int        errs = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  vector_l2_normalize dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Floor of the square root, one result bit at a time from the top
  function automatic norm_t root_floor(sum_t v);
    norm_t       r;
    norm_t       t;
    logic [37:0] sq;
    r = '0;
    for (int i = NormW - 1; i >= 0; i--) begin
      t  = r | (norm_t'(1) << i);
      sq = t * t;
      if (sq <= {1'b0, v}) r = t;
    end
    return r;
  endfunction

  // Q4.12 element over the norm into Q1.15, truncated, clamped at full scale
  function automatic logic [15:0] scale_unit(elem_t e, norm_t n);
    logic [31:0] mag;
    logic [31:0] q;
    if (n == '0) return e;
    mag = e[15] ? 32'(-int'(e)) : 32'(int'(e));
    q   = (mag << 15) / {13'd0, n};
    if (e[15]) begin
      if (q > 32'd32768) q = 32'd32768;
      return 16'(-q);
    end
    if (q > 32'd32767) q = 32'd32767;
    return q[15:0];
  endfunction

  // Buffer one accepted element; on closing, queue one result per element
  task automatic norm_predict(logic [15:0] raw, logic last);
    elem_t       e;
    logic [31:0] sq;
    norm_t       n;
    e  = elem_t'(raw);
    sq = 32'(int'(e) * int'(e));
    vec_q.push_back(e);
    sq_acc = sq_acc + {5'd0, sq};
    if (last || vec_q.size() == MaxLen) begin
      n = root_floor(sq_acc);
      foreach (vec_q[k]) begin
        unit_due_q.push_back('{scale_unit(vec_q[k], n), n, k == vec_q.size() - 1});
      end
      vec_q.delete();
      sq_acc = '0;
    end
  endtask

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(logic [15:0] e, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= e;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending until every queued result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (unit_due_q.size() != 0);
  endtask

  // Random element: zeros, extremes, small values and the full range
  function automatic logic [15:0] rand_elem();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 15) return 16'h7fff;
    if (r < 20) return 16'h8000;
    if (r < 50) return 16'($signed($urandom_range(600)) - 300);
    return 16'($urandom());
  endfunction

  // Check each accepted result against the oldest expectation; randomize tready
  always @(posedge clk_i) begin
    unit_res_t got;
    unit_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[34:16], m_axis_tlast};
      if (unit_due_q.size() == 0) begin
        $display("%0t unexpected item: unit_element %0d norm %0d is_final %0d",
                 $time, $signed(got.unit), got.norm, got.fin);
        errs++;
      end else begin
        want = unit_due_q.pop_front();
        if (got.unit !== want.unit) begin
          $display("%0t unit_element mismatch: expected %0d, got %0d",
                   $time, $signed(want.unit), $signed(got.unit));
          errs++;
        end
        if (got.norm !== want.norm) begin
          $display("%0t norm mismatch: expected %0d, got %0d", $time, want.norm, got.norm);
          errs++;
        end
        if (got.fin !== want.fin) begin
          $display("%0t is_final mismatch: expected %0d, got %0d", $time, want.fin, got.fin);
          errs++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Stimulus
  initial begin
    int sent;
    int vec_no;
    int len;
    int phase;
    int cur_phase;
    bit zero_vec;
    logic [15:0] e;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < DirN; i++) begin
      send_item(DirTab[i].elem, DirTab[i].last);
      norm_predict(DirTab[i].elem, DirTab[i].last);
      if (DirTab[i].typed) begin
        // single-element vector: swap the predicted result for the typed one
        void'(unit_due_q.pop_back());
        unit_due_q.push_back(DirTab[i].res);
      end
    end
    wait_drained();

    // Random vectors, idle and stall settings changing by phase
    sent      = 0;
    vec_no    = 0;
    cur_phase = -1;
    while (sent < RandItems) begin
      phase = (sent / PhaseLen) % 4;
      if (phase != cur_phase) begin
        wait_drained();
        cur_phase = phase;
        case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 64; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 64; end
          default: begin idle_pct = 23; stall_pct = 23; end
        endcase
      end
      if (vec_no == 2) begin
        // full store without a last mark, largest possible norm
        for (int k = 0; k < MaxLen; k++) begin
          send_item(16'h8000, 1'b0);
          norm_predict(16'h8000, 1'b0);
        end
        sent += MaxLen;
      end else begin
        len = (vec_no == 9) ? MaxLen :
              ($urandom_range(99) < 75) ? $urandom_range(8, 1) :
              ($urandom_range(99) < 80) ? $urandom_range(24, 9) : $urandom_range(63, 25);
        zero_vec = ($urandom_range(99) < 10);
        for (int k = 0; k < len; k++) begin
          e = zero_vec ? 16'h0000 : rand_elem();
          send_item(e, k == len - 1);
          norm_predict(e, k == len - 1);
        end
        sent += len;
      end
      vec_no++;
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ vector_l2_normalize.f @@
src/vln_pkg.sv
src/vln_store.sv
src/vln_isqrt.sv
src/vln_scale.sv
src/vector_l2_normalize.sv
tb/tb_vector_l2_normalize.sv
